// ===== hdl/kmuf_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the spanning-tree block.
`timescale 1ns / 1ps
package kmuf_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = VTX_W + 1;
   localparam int EIDX_W       = $clog2(MAX_EDGES);
   localparam int ECNT_W       = EIDX_W + 1;
   localparam int WGT_W        = 32;
   localparam int TOT_W        = 40;
   localparam int KEY_W        = WGT_W + EIDX_W;

   typedef struct packed {
      logic [VTX_W-1:0] src;
      logic [VTX_W-1:0] dst;
      logic [WGT_W-1:0] weight;
   } edge_type;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_INIT    = 9'b000000010,
      ST_SETUP   = 9'b000000100,
      ST_SCAN    = 9'b000001000,
      ST_DECIDE  = 9'b000010000,
      ST_LOOKUP  = 9'b000100000,
      ST_COMPARE = 9'b001000000,
      ST_MERGE   = 9'b010000000,
      ST_FINISH  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic run_clear;
      logic init_step;
      logic scan_begin;
      logic scan_step;
      logic decide;
      logic lookup;
      logic take;
      logic merge_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic room_left;
      logic scan_done;
      logic best_found;
      logic best_in_range;
      logic labels_differ;
      logic merge_done;
   } stat_type;

endpackage

// ===== hdl/kmuf_ctrl.sv =====
// Sequencing state machine for loading edges and running the spanning-tree search.
`timescale 1ns / 1ps
module kmuf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last,
   input  kmuf_pkg::stat_type stat,
   output kmuf_pkg::cmd_type  cmd,
   output logic               busy
);

   kmuf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         kmuf_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.run_clear = 1'b1;
                  state_in      = kmuf_pkg::ST_INIT;
               end
            end
         end
         kmuf_pkg::ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_done) begin
               state_in = kmuf_pkg::ST_SETUP;
            end
         end
         kmuf_pkg::ST_SETUP: begin
            cmd.scan_begin = 1'b1;
            state_in = stat.room_left ? kmuf_pkg::ST_SCAN : kmuf_pkg::ST_FINISH;
         end
         kmuf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = kmuf_pkg::ST_DECIDE;
            end
         end
         kmuf_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (!stat.best_found) begin
               state_in = kmuf_pkg::ST_FINISH;
            end else if (!stat.best_in_range) begin
               state_in = kmuf_pkg::ST_SETUP;
            end else begin
               state_in = kmuf_pkg::ST_LOOKUP;
            end
         end
         kmuf_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = kmuf_pkg::ST_COMPARE;
         end
         kmuf_pkg::ST_COMPARE: begin
            if (stat.labels_differ) begin
               cmd.take = 1'b1;
               state_in = kmuf_pkg::ST_MERGE;
            end else begin
               state_in = kmuf_pkg::ST_SETUP;
            end
         end
         kmuf_pkg::ST_MERGE: begin
            cmd.merge_step = 1'b1;
            if (stat.merge_done) begin
               state_in = kmuf_pkg::ST_SETUP;
            end
         end
         kmuf_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = kmuf_pkg::ST_IDLE;
         end
         default: begin
            state_in = kmuf_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != kmuf_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmuf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/kmuf_dp.sv =====
// Datapath: edge store, ordered selection scan, component labels and result registers.
`timescale 1ns / 1ps
module kmuf_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  kmuf_pkg::cmd_type                 cmd,
   output kmuf_pkg::stat_type                stat,
   input  logic [kmuf_pkg::VTX_W-1:0]        req_edge_source,
   input  logic [kmuf_pkg::VTX_W-1:0]        req_edge_dest,
   input  logic [kmuf_pkg::WGT_W-1:0]        req_edge_weight,
   input  logic                              csr_we,
   input  logic [kmuf_pkg::VCNT_W-1:0]       csr_wdata,
   output logic                              rsp_valid,
   output logic [kmuf_pkg::VTX_W-1:0]        rsp_tree_source,
   output logic [kmuf_pkg::VTX_W-1:0]        rsp_tree_dest,
   output logic [kmuf_pkg::WGT_W-1:0]        rsp_tree_weight,
   output logic [kmuf_pkg::TOT_W-1:0]        rsp_running_total,
   output logic                              rsp_entry_valid,
   output logic                              rsp_overflow_seen,
   output logic                              rsp_run_last
);

   localparam int VTX_W  = kmuf_pkg::VTX_W;
   localparam int VCNT_W = kmuf_pkg::VCNT_W;
   localparam int EIDX_W = kmuf_pkg::EIDX_W;
   localparam int ECNT_W = kmuf_pkg::ECNT_W;
   localparam int TOT_W  = kmuf_pkg::TOT_W;
   localparam int KEY_W  = kmuf_pkg::KEY_W;

   // Memories
   kmuf_pkg::edge_type edge_mem [kmuf_pkg::MAX_EDGES];
   logic [VTX_W-1:0]   lab_mem  [kmuf_pkg::MAX_VERTICES];

   // Registers
   logic [VCNT_W-1:0]  vcount_ff, vcount_in;
   logic [ECNT_W-1:0]  ecount_ff, ecount_in;
   logic               ovf_ff, ovf_in;
   logic [VTX_W-1:0]   icnt_ff, icnt_in;
   logic [VTX_W-1:0]   taken_ff, taken_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [ECNT_W-1:0]  sidx_ff, sidx_in;
   logic               rd_valid_ff, rd_valid_in;
   kmuf_pkg::edge_type rd_edge_ff;
   logic [EIDX_W-1:0]  rd_idx_ff;
   logic               best_found_ff, best_found_in;
   kmuf_pkg::edge_type best_edge_ff, best_edge_in;
   logic [EIDX_W-1:0]  best_idx_ff, best_idx_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [KEY_W-1:0]   prev_key_ff, prev_key_in;
   logic [VTX_W-1:0]   la_ff, lb_ff;
   logic [VCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic               mrd_valid_ff, mrd_valid_in;
   logic [VTX_W-1:0]   mdata_ff;
   logic [VTX_W-1:0]   maddr_ff;
   logic               pend_valid_ff, pend_valid_in;
   kmuf_pkg::edge_type pend_edge_ff, pend_edge_in;
   logic [TOT_W-1:0]   pend_total_ff, pend_total_in;
   logic               out_valid_ff, out_valid_in;
   kmuf_pkg::edge_type out_edge_ff, out_edge_in;
   logic [TOT_W-1:0]   out_total_ff, out_total_in;
   logic               out_entry_ff, out_entry_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               out_last_ff, out_last_in;

   // Combinational
   logic [VCNT_W-1:0]  nv;
   logic               load_in_range;
   logic               edge_we;
   logic               scan_issue;
   logic               merge_issue;
   logic [KEY_W-1:0]   rd_key;
   logic [KEY_W-1:0]   best_key;
   logic               cand;
   logic               lab_we;
   logic [VTX_W-1:0]   lab_waddr;
   logic [VTX_W-1:0]   lab_wdata;
   logic [TOT_W-1:0]   sum_total;

   always_comb begin
      if (vcount_ff == '0) begin
         nv = VCNT_W'(1);
      end else if (vcount_ff > VCNT_W'(kmuf_pkg::MAX_VERTICES)) begin
         nv = VCNT_W'(kmuf_pkg::MAX_VERTICES);
      end else begin
         nv = vcount_ff;
      end
   end

   assign load_in_range = ({1'b0, req_edge_source} < nv) && ({1'b0, req_edge_dest} < nv);
   assign edge_we     = cmd.load && load_in_range &&
                        (ecount_ff < ECNT_W'(kmuf_pkg::MAX_EDGES));
   assign scan_issue  = cmd.scan_step && (sidx_ff < ecount_ff);
   assign merge_issue = cmd.merge_step && (mcnt_ff < VCNT_W'(kmuf_pkg::MAX_VERTICES));
   assign rd_key      = {rd_edge_ff.weight, rd_idx_ff};
   assign best_key    = {best_edge_ff.weight, best_idx_ff};
   assign cand        = cmd.scan_step && rd_valid_ff &&
                        (!prev_valid_ff || (rd_key > prev_key_ff)) &&
                        (!best_found_ff || (rd_key < best_key));
   assign sum_total   = total_ff + TOT_W'(best_edge_ff.weight);

   always_comb begin
      lab_we    = 1'b0;
      lab_waddr = icnt_ff;
      lab_wdata = icnt_ff;
      if (cmd.init_step) begin
         lab_we = 1'b1;
      end else if (mrd_valid_ff && (mdata_ff == lb_ff)) begin
         lab_we    = 1'b1;
         lab_waddr = maddr_ff;
         lab_wdata = la_ff;
      end
   end

   always_comb begin
      vcount_in     = csr_we ? csr_wdata : vcount_ff;
      ecount_in     = edge_we ? ecount_ff + ECNT_W'(1) : ecount_ff;
      ovf_in        = ovf_ff | (cmd.load && load_in_range && !edge_we);
      icnt_in       = cmd.init_step ? icnt_ff + VTX_W'(1) : icnt_ff;
      taken_in      = taken_ff;
      total_in      = total_ff;
      sidx_in       = scan_issue ? sidx_ff + ECNT_W'(1) : sidx_ff;
      rd_valid_in   = scan_issue;
      best_found_in = best_found_ff | cand;
      best_edge_in  = cand ? rd_edge_ff : best_edge_ff;
      best_idx_in   = cand ? rd_idx_ff : best_idx_ff;
      prev_valid_in = prev_valid_ff;
      prev_key_in   = prev_key_ff;
      mcnt_in       = merge_issue ? mcnt_ff + VCNT_W'(1) : mcnt_ff;
      mrd_valid_in  = merge_issue;
      pend_valid_in = pend_valid_ff;
      pend_edge_in  = pend_edge_ff;
      pend_total_in = pend_total_ff;
      out_valid_in  = 1'b0;
      out_edge_in   = out_edge_ff;
      out_total_in  = out_total_ff;
      out_entry_in  = out_entry_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;

      if (cmd.run_clear) begin
         icnt_in       = '0;
         taken_in      = '0;
         total_in      = '0;
         prev_valid_in = 1'b0;
         pend_valid_in = 1'b0;
      end
      if (cmd.scan_begin) begin
         sidx_in       = '0;
         rd_valid_in   = 1'b0;
         best_found_in = 1'b0;
      end
      if (cmd.decide) begin
         prev_valid_in = 1'b1;
         prev_key_in   = best_key;
      end
      if (cmd.take) begin
         // The previous chosen edge is now known not to be the last one.
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_edge_in  = pend_edge_ff;
            out_total_in = pend_total_ff;
            out_entry_in = 1'b1;
            out_ovf_in   = ovf_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_edge_in  = best_edge_ff;
         pend_total_in = sum_total;
         total_in      = sum_total;
         taken_in      = taken_ff + VTX_W'(1);
         mcnt_in       = '0;
         mrd_valid_in  = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_ovf_in    = ovf_ff;
         out_last_in   = 1'b1;
         if (pend_valid_ff) begin
            out_edge_in  = pend_edge_ff;
            out_total_in = pend_total_ff;
            out_entry_in = 1'b1;
         end else begin
            out_edge_in  = '0;
            out_total_in = '0;
            out_entry_in = 1'b0;
         end
         pend_valid_in = 1'b0;
         ecount_in     = '0;
         ovf_in        = 1'b0;
      end
   end

   always_comb begin
      stat.init_done     = (icnt_ff == VTX_W'(kmuf_pkg::MAX_VERTICES - 1));
      stat.room_left     = ({1'b0, taken_ff} + VCNT_W'(1)) < nv;
      stat.scan_done     = !(sidx_ff < ecount_ff) && !rd_valid_ff;
      stat.best_found    = best_found_ff;
      stat.best_in_range = ({1'b0, best_edge_ff.src} < nv) && ({1'b0, best_edge_ff.dst} < nv);
      stat.labels_differ = (la_ff != lb_ff);
      stat.merge_done    = !(mcnt_ff < VCNT_W'(kmuf_pkg::MAX_VERTICES)) && !mrd_valid_ff;
   end

   // Edge store: one write port for loading, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[ecount_ff[EIDX_W-1:0]] <= '{src: req_edge_source, dst: req_edge_dest,
                                               weight: req_edge_weight};
      end
      if (scan_issue) begin
         rd_edge_ff <= edge_mem[sidx_ff[EIDX_W-1:0]];
         rd_idx_ff  <= sidx_ff[EIDX_W-1:0];
      end
   end

   // Component labels: one write port, three registered read ports.
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      if (cmd.lookup) begin
         la_ff <= lab_mem[best_edge_ff.src];
         lb_ff <= lab_mem[best_edge_ff.dst];
      end
      if (merge_issue) begin
         mdata_ff <= lab_mem[mcnt_ff[VTX_W-1:0]];
         maddr_ff <= mcnt_ff[VTX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= VCNT_W'(kmuf_pkg::MAX_VERTICES);
         ecount_ff     <= '0;
         ovf_ff        <= 1'b0;
         icnt_ff       <= '0;
         taken_ff      <= '0;
         total_ff      <= '0;
         sidx_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         mcnt_ff       <= '0;
         mrd_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         vcount_ff     <= vcount_in;
         ecount_ff     <= ecount_in;
         ovf_ff        <= ovf_in;
         icnt_ff       <= icnt_in;
         taken_ff      <= taken_in;
         total_ff      <= total_in;
         sidx_ff       <= sidx_in;
         rd_valid_ff   <= rd_valid_in;
         best_found_ff <= best_found_in;
         prev_valid_ff <= prev_valid_in;
         mcnt_ff       <= mcnt_in;
         mrd_valid_ff  <= mrd_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_edge_ff  <= best_edge_in;
      best_idx_ff   <= best_idx_in;
      prev_key_ff   <= prev_key_in;
      pend_edge_ff  <= pend_edge_in;
      pend_total_ff <= pend_total_in;
      out_edge_ff   <= out_edge_in;
      out_total_ff  <= out_total_in;
      out_entry_ff  <= out_entry_in;
      out_ovf_ff    <= out_ovf_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tree_source   = out_edge_ff.src;
   assign rsp_tree_dest     = out_edge_ff.dst;
   assign rsp_tree_weight   = out_edge_ff.weight;
   assign rsp_running_total = out_total_ff;
   assign rsp_entry_valid   = out_entry_ff;
   assign rsp_overflow_seen = out_ovf_ff;
   assign rsp_run_last      = out_last_ff;

endmodule

// ===== hdl/kruskal_mst_union_find.sv =====
// Top level of the minimum spanning tree block: controller and datapath.
`timescale 1ns / 1ps
// Usage. Edges are loaded one item at a time: an item is taken at a rising edge where start
// is high and busy is low. Edges with an endpoint not below the vertex count are ignored; an
// edge that finds the 256-entry store full is dropped and the overflow flag is raised.
// An item with req_edge_last set starts a run and holds busy high until the run is over.
// Non-last items leave the block idle, so edges may be loaded on every cycle.
// The run first sets every vertex to its own component. It then repeatedly scans the edge
// store for the next edge in (weight, load order); an edge that is in range then has the
// labels of its two endpoints looked up and compared. The single read port of the edge store
// sets most of the run time. A chosen edge adds a relabelling sweep over the 64 component
// labels. A run ends after vertex_count-1 chosen edges or when the edges are exhausted.
// Each result is presented for exactly one cycle with rsp_valid high; the receiver cannot
// stall. A chosen edge is shown once the next one is found or the run ends, so that the last
// result can carry rsp_run_last. A run that chooses nothing gives one result with
// rsp_entry_valid low. The vertex count register is written through csr_we and csr_wdata;
// the user must write it only while the block is idle, as the block does not enforce this.
// Reset is synchronous and sets the vertex count to 64 and empties the edge store.
module kruskal_mst_union_find (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [kmuf_pkg::VTX_W-1:0]   req_edge_source,
   input  logic [kmuf_pkg::VTX_W-1:0]   req_edge_dest,
   input  logic [kmuf_pkg::WGT_W-1:0]   req_edge_weight,
   input  logic                         req_edge_last,
   output logic                         rsp_valid,
   output logic [kmuf_pkg::VTX_W-1:0]   rsp_tree_source,
   output logic [kmuf_pkg::VTX_W-1:0]   rsp_tree_dest,
   output logic [kmuf_pkg::WGT_W-1:0]   rsp_tree_weight,
   output logic [kmuf_pkg::TOT_W-1:0]   rsp_running_total,
   output logic                         rsp_entry_valid,
   output logic                         rsp_overflow_seen,
   output logic                         rsp_run_last,
   input  logic                         csr_we,
   input  logic [kmuf_pkg::VCNT_W-1:0]  csr_wdata
);

   // Commands run from the controller to the datapath, status flags come back.
   kmuf_pkg::cmd_type  cmd;
   kmuf_pkg::stat_type stat;

   kmuf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_edge_last),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the edge store, the labels and the output registers.
   kmuf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_edge_source   (req_edge_source),
      .req_edge_dest     (req_edge_dest),
      .req_edge_weight   (req_edge_weight),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_tree_source   (rsp_tree_source),
      .rsp_tree_dest     (rsp_tree_dest),
      .rsp_tree_weight   (rsp_tree_weight),
      .rsp_running_total (rsp_running_total),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

// ===== tb/tb_kruskal_mst_union_find.sv =====
// Testbench for the Kruskal spanning-tree block: stimulus, tree predictor and result check.
`timescale 1ns / 1ps

typedef struct packed {
   logic [5:0]  src;
   logic [5:0]  dst;
   logic [31:0] weight;
   logic [39:0] total;
   logic        valid;
   logic        ovf;
   logic        last;
} tree_result_type;

class scoreboard_type;
   int unsigned     vcount;
   tree_result_type pending_tree[$];
   logic [5:0]      load_src[$];
   logic [5:0]      load_dst[$];
   logic [31:0]     load_wgt[$];
   bit              dropped;
   int              mismatches;

   function void reset_state();
      vcount = 64;
      dropped = 0;
      mismatches = 0;
      load_src.delete();
      load_dst.delete();
      load_wgt.delete();
      pending_tree.delete();
   endfunction

   // Effective vertex count: zero behaves as one, anything above 64 as 64.
   function int unsigned live_vertices();
      if (vcount == 0) return 1;
      if (vcount > kmuf_pkg::MAX_VERTICES) return kmuf_pkg::MAX_VERTICES;
      return vcount;
   endfunction

   // Note an accepted item; the item marked last produces the whole tree.
   function void note_edge(logic [5:0] s, logic [5:0] d, logic [31:0] w, logic last);
      int unsigned     nv;
      int              order[$];
      int              parent[64];
      int              rs, rd, j, cur, taken;
      logic [39:0]     sum;
      tree_result_type r;
      nv = live_vertices();
      if (s < nv && d < nv) begin
         if (load_src.size() < kmuf_pkg::MAX_EDGES) begin
            load_src = {load_src, s};
            load_dst = {load_dst, d};
            load_wgt = {load_wgt, w};
         end else begin
            dropped = 1;
         end
      end
      if (!last) return;
      // Stable insertion sort on weight, so ties stay in load order.
      for (int i = 0; i < load_src.size(); i++) begin
         cur = i;
         j = order.size();
         while (j > 0 && load_wgt[order[j-1]] > load_wgt[cur]) j--;
         order.insert(j, cur);
      end
      for (int v = 0; v < 64; v++) parent[v] = v;
      taken = 0;
      sum = '0;
      foreach (order[k]) begin
         if (taken + 1 >= nv) break;
         if (load_src[order[k]] >= nv || load_dst[order[k]] >= nv) continue;
         rs = load_src[order[k]];
         while (parent[rs] != rs) rs = parent[rs];
         rd = load_dst[order[k]];
         while (parent[rd] != rd) rd = parent[rd];
         if (rs != rd) begin
            parent[rd] = rs;
            sum = sum + load_wgt[order[k]];
            r.src = load_src[order[k]];
            r.dst = load_dst[order[k]];
            r.weight = load_wgt[order[k]];
            r.total = sum;
            r.valid = 1;
            r.ovf = dropped;
            r.last = 0;
            pending_tree = {pending_tree, r};
            taken++;
         end
      end
      if (taken == 0) begin
         r = '{6'd0, 6'd0, 32'd0, 40'd0, 1'b0, dropped, 1'b1};
         pending_tree = {pending_tree, r};
      end else begin
         pending_tree[pending_tree.size()-1].last = 1;
      end
      load_src.delete();
      load_dst.delete();
      load_wgt.delete();
      dropped = 0;
   endfunction

   function void check_result(tree_result_type got);
      tree_result_type want;
      if (pending_tree.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result src=%0d dst=%0d", got.src, got.dst);
         return;
      end
      want = pending_tree.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: want s=%0d d=%0d w=%h t=%h v=%b o=%b l=%b",
                     want.src, want.dst, want.weight, want.total, want.valid, want.ovf,
                     want.last);
            $display("          got  s=%0d d=%0d w=%h t=%h v=%b o=%b l=%b",
                     got.src, got.dst, got.weight, got.total, got.valid, got.ovf, got.last);
         end
      end
   endfunction
endclass

module tb_kruskal_mst_union_find;
   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [5:0]  req_edge_source = '0;
   logic [5:0]  req_edge_dest = '0;
   logic [31:0] req_edge_weight = '0;
   logic        req_edge_last = 0;
   logic        rsp_valid;
   logic [5:0]  rsp_tree_source;
   logic [5:0]  rsp_tree_dest;
   logic [31:0] rsp_tree_weight;
   logic [39:0] rsp_running_total;
   logic        rsp_entry_valid;
   logic        rsp_overflow_seen;
   logic        rsp_run_last;
   logic        csr_we = 0;
   logic [6:0]  csr_wdata = '0;

   scoreboard_type sb;
   // When clear, the sender never inserts gaps; used for one long stretch of runs.
   bit gaps_on = 1;
   int edges_sent = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   kruskal_mst_union_find u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_edge_source(req_edge_source), .req_edge_dest(req_edge_dest),
      .req_edge_weight(req_edge_weight), .req_edge_last(req_edge_last),
      .rsp_valid(rsp_valid), .rsp_tree_source(rsp_tree_source),
      .rsp_tree_dest(rsp_tree_dest), .rsp_tree_weight(rsp_tree_weight),
      .rsp_running_total(rsp_running_total), .rsp_entry_valid(rsp_entry_valid),
      .rsp_overflow_seen(rsp_overflow_seen), .rsp_run_last(rsp_run_last),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Results are sampled at the edge that ends their single cycle; the values read here are
   // those from before the edge, since the block updates its outputs with nonblocking writes.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_tree_source, rsp_tree_dest, rsp_tree_weight, rsp_running_total,
                           rsp_entry_valid, rsp_overflow_seen, rsp_run_last});
   end

   // Present one item and hold it until the block takes it. Busy is looked at on the falling
   // edge, where it is settled, so the following rising edge is the one that accepts the item.
   // Start is left high on return so that back-to-back items need no second write; after a
   // last item it is dropped before the task returns, since the block is busy by then anyway.
   task automatic send_edge(input logic [5:0] s, input logic [5:0] d, input logic [31:0] w,
                            input logic last);
      if (gaps_on && $urandom_range(99) < 6) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1;
      req_edge_source <= s;
      req_edge_dest <= d;
      req_edge_weight <= w;
      req_edge_last <= last;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      sb.note_edge(s, d, w, last);
      edges_sent++;
      if (last) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   // The register is only written once the previous run has delivered every result and
   // the block has dropped busy, plus a short margin.
   task automatic write_vertex_count(input logic [6:0] v);
      while (sb.pending_tree.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.vcount = v;
   endtask

   // Random run: endpoints mostly in range, weights often narrow so that ties are common.
   task automatic random_run(input int n);
      int unsigned nv;
      logic [5:0]  s, d;
      logic [31:0] w;
      nv = sb.live_vertices();
      for (int i = 0; i < n; i++) begin
         s = ($urandom_range(99) < 90) ? 6'($urandom_range(nv - 1)) : 6'($urandom_range(63));
         d = ($urandom_range(99) < 90) ? 6'($urandom_range(nv - 1)) : 6'($urandom_range(63));
         w = ($urandom_range(1)) ? $urandom_range(15) : $urandom;
         send_edge(s, d, w, i == n - 1);
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // A single vertex: a self-loop is stored but can never be chosen, so one empty result.
      write_vertex_count(7'd1);
      send_edge(6'd1, 6'd0, 32'd9, 0);
      send_edge(6'd0, 6'd0, 32'd5, 1);
      // Zero behaves as one vertex.
      write_vertex_count(7'd0);
      send_edge(6'd0, 6'd0, 32'hFFFF_FFFF, 1);
      // Above the maximum behaves as 64: extreme endpoints and weights, ties, a self-loop.
      write_vertex_count(7'd127);
      send_edge(6'd63, 6'd0, 32'hFFFF_FFFF, 0);
      send_edge(6'd0, 6'd63, 32'd0, 0);
      send_edge(6'd62, 6'd63, 32'd7, 0);
      send_edge(6'd62, 6'd0, 32'd7, 0);
      send_edge(6'd5, 6'd5, 32'd0, 0);
      send_edge(6'd63, 6'd63, 32'hFFFF_FFFF, 1);
      // A last mark on an ignored edge still starts the run.
      write_vertex_count(7'd4);
      send_edge(6'd1, 6'd2, 32'd3, 0);
      send_edge(6'd2, 6'd3, 32'd3, 0);
      send_edge(6'd5, 6'd1, 32'd1, 1);
      // Last item ignored with nothing stored: an empty result.
      send_edge(6'd9, 6'd1, 32'd1, 1);
      // Store overflow: more in-range edges than the store holds; two vertices keep it short.
      write_vertex_count(7'd2);
      for (int i = 0; i < 259; i++)
         send_edge(6'(i % 2), 6'((i + 1) % 2), $urandom, i == 258);
      write_vertex_count(7'd64);
      send_edge(6'd10, 6'd20, 32'd4, 1);

      // Random runs with changing vertex counts; a middle stretch runs without sender gaps.
      while (edges_sent < 420) begin
         gaps_on = !(edges_sent > 290 && edges_sent < 370);
         case ($urandom_range(7))
            0:       write_vertex_count(7'd64);
            1:       write_vertex_count(7'($urandom_range(127)));
            default: write_vertex_count(7'($urandom_range(2, 12)));
         endcase
         random_run(($urandom_range(9) == 0) ? 40 : $urandom_range(1, 14));
      end

      while (sb.pending_tree.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_tree.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
